// File: hdl/ed25519_point_on_curve_check_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Ed25519 point check
// Each macro is either a concurrent assertion or empty, as SYNTH selects.
// ----------------------------------------------------------------------------
`ifndef ED25519_POINT_ON_CURVE_CHECK_TOP_ASSERT_SVH
`define ED25519_POINT_ON_CURVE_CHECK_TOP_ASSERT_SVH
`ifndef SYNTH
`define EDPOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edpoc same-cycle check failed");
`define EDPOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edpoc next-cycle check failed");
`else
`define EDPOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EDPOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/edpoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpoc_pkg
// Field constants and widths for the Ed25519 point check.
// ----------------------------------------------------------------------------
package edpoc_pkg;

    localparam int WORD_W = 64;
    localparam int FE_W   = 255;

    // field prime 2^255 - 19 and p - 1
    localparam logic [FE_W-1:0] P    =
        255'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFED;
    localparam logic [FE_W-1:0] P_M1 = P - 255'd1;

    // Edwards curve constant d
    localparam logic [FE_W-1:0] CURVE_D =
        255'h52036CEE_2B6FFE73_8CC74079_7779E898_00700A4D_4141D8AB_75EB4DCA_135978A3;

    // exponents p - 2 and (p - 1) / 2
    localparam logic [255:0] EXP_INV = {1'b0, P} - 256'd2;
    localparam logic [255:0] EXP_LEG = {2'b0, P_M1[FE_W-1:1]};

endpackage

// File: hdl/edpoc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpoc_in_if / edpoc_out_if
// Valid/ready channels for compressed points and check results.
// ----------------------------------------------------------------------------
interface edpoc_in_if;
    logic                        valid;
    logic                        ready;
    logic [edpoc_pkg::WORD_W-1:0] point_word0;
    logic [edpoc_pkg::WORD_W-1:0] point_word1;
    logic [edpoc_pkg::WORD_W-1:0] point_word2;
    logic [edpoc_pkg::WORD_W-1:0] point_word3;

    modport source (output valid, point_word0, point_word1, point_word2, point_word3,
                    input ready);
    modport sink   (input valid, point_word0, point_word1, point_word2, point_word3,
                    output ready);
endinterface

interface edpoc_out_if;
    logic valid;
    logic ready;
    logic curve_ok;
    logic y_out_of_range;

    modport source (output valid, curve_ok, y_out_of_range, input ready);
    modport sink   (input valid, curve_ok, y_out_of_range, output ready);
endinterface

// File: hdl/ed25519_point_on_curve_check_top.sv
`timescale 1ns / 1ps
// Work: about 1,020 field products for an in-range point, each from one 32x32
//   multiplier stepping 64 partial products; a point whose Y is not below p skips
//   the field products and goes to S_DONE; results leave through an output register.
// A one-deep input buffer takes a new request while the last one is worked on.
// Reset: synchronous, active low; clears control state only, the operand memory is
//   not cleared and every entry is written before it is read.
// ----------------------------------------------------------------------------
// ed25519_point_on_curve_check_top
// Checks that a compressed Ed25519 Y coordinate decompresses to a curve point,
// using an operand memory, a sequencer and a shared modular multiplier.
// ----------------------------------------------------------------------------
module ed25519_point_on_curve_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    edpoc_in_if.sink    i_point,
    edpoc_out_if.source o_result
);

    localparam int FE_W = edpoc_pkg::FE_W;

    // operand memory entries
    localparam logic [2:0] E_Y   = 3'd0;
    localparam logic [2:0] E_Y2  = 3'd1;
    localparam logic [2:0] E_U   = 3'd2;
    localparam logic [2:0] E_V   = 3'd3;
    localparam logic [2:0] E_ACC = 3'd4;
    localparam logic [2:0] E_X2  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_MRD, S_MLD, S_MACC, S_MRED, S_MWR,
        S_ARD, S_AU, S_AV, S_INIT, S_FRD, S_FCMP, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_Y2, OP_DV, OP_SQ, OP_MB, OP_XU
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic   r_pow;
    logic [7:0] r_bit;

    // input buffer
    logic r_buf_valid;
    logic [edpoc_pkg::WORD_W-1:0] r_buf0, r_buf1, r_buf2, r_buf3;

    // output register and result hold
    logic r_out_valid, r_out_on, r_out_oor;
    logic r_res_on, r_res_oor;

    // operand memory
    logic [FE_W-1:0] r_mem [0:5];
    logic [FE_W-1:0] r_rd_a, r_rd_b;
    logic [2:0]      w_ra, w_rb, w_wa;
    logic            w_we;
    logic [FE_W-1:0] w_wd;

    // multiplier datapath
    logic [255:0] r_ma, r_mb;
    logic [63:0]  r_prod;
    logic [3:0]   r_pshift;
    logic         r_pvalid;
    logic [6:0]   r_cnt;
    logic [511:0] r_acc;

    logic [FE_W-1:0] w_y, w_low, w_canon, w_sub1, w_add1, w_t;
    logic            w_oor, w_exp_bit;
    logic [256:0]    w_hi;
    logic [261:0]    w_hi19;
    logic [262:0]    w_fold;
    logic [511:0]    w_pp;
    logic [2:0]      w_dest;

    assign i_point.ready           = !r_buf_valid;
    assign o_result.valid          = r_out_valid;
    assign o_result.curve_ok       = r_out_on;
    assign o_result.y_out_of_range = r_out_oor;

    // form Y and check range
    assign w_y   = {r_buf3[62:0], r_buf2, r_buf1, r_buf0};
    assign w_oor = (w_y >= edpoc_pkg::P);

    // exponent bit for the current power step
    assign w_exp_bit = r_pow ? edpoc_pkg::EXP_LEG[r_bit] : edpoc_pkg::EXP_INV[r_bit];

    // partial product placement, folding by 2^255 = 19, final canonical step
    assign w_pp    = {448'b0, r_prod} << {r_pshift, 5'b0};
    assign w_hi    = r_acc[511:255];
    assign w_hi19  = {1'b0, w_hi, 4'b0} + {4'b0, w_hi, 1'b0} + {5'b0, w_hi};
    assign w_fold  = {8'b0, r_acc[254:0]} + {1'b0, w_hi19};
    assign w_low   = r_acc[254:0];
    assign w_canon = (w_low >= edpoc_pkg::P) ? (w_low - edpoc_pkg::P) : w_low;

    // u = y^2 - 1 and v = d*y^2 + 1
    assign w_sub1 = (r_rd_a == '0) ? edpoc_pkg::P_M1 : (r_rd_a - 255'd1);
    assign w_t    = r_rd_b + 255'd1;
    assign w_add1 = (w_t == edpoc_pkg::P) ? '0 : w_t;

    // select memory addresses
    always_comb begin
        w_dest = E_ACC;
        case (r_op)
            OP_Y2: begin w_ra = E_Y;   w_rb = E_Y;  w_dest = E_Y2; end
            OP_DV: begin w_ra = E_Y2;  w_rb = E_Y2; w_dest = E_V;  end
            OP_SQ: begin w_ra = E_ACC; w_rb = E_ACC; end
            OP_MB: begin w_ra = E_ACC; w_rb = r_pow ? E_X2 : E_V; end
            OP_XU: begin w_ra = E_ACC; w_rb = E_U;  w_dest = E_X2; end
            default: begin w_ra = E_ACC; w_rb = E_ACC; end
        endcase
        case (r_state)
            S_ARD, S_AU, S_AV: begin w_ra = E_Y2;  w_rb = E_V; end
            S_FRD, S_FCMP:     begin w_ra = E_ACC; w_rb = E_ACC; end
            default: ;
        endcase
    end

    // select memory write
    always_comb begin
        w_we = 1'b0;
        w_wa = E_Y;
        w_wd = w_y;
        case (r_state)
            S_IDLE: w_we = r_buf_valid;
            S_MWR:  begin w_we = 1'b1; w_wa = w_dest; w_wd = w_canon; end
            S_AU:   begin w_we = 1'b1; w_wa = E_U;    w_wd = w_sub1;  end
            S_AV:   begin w_we = 1'b1; w_wa = E_V;    w_wd = w_add1;  end
            S_INIT: begin w_we = 1'b1; w_wa = E_ACC;  w_wd = 255'd1;  end
            default: ;
        endcase
    end

    // write operand memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    // read operand memory, registered data
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_rb];
    end

    // sequencer, multiplier and handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_Y2;
            r_pow       <= 1'b0;
            r_bit       <= 8'd255;
            r_buf_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pvalid    <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // hold a new request in the buffer
            if (i_point.valid && i_point.ready) begin
                r_buf_valid <= 1'b1;
                r_buf0 <= i_point.point_word0;
                r_buf1 <= i_point.point_word1;
                r_buf2 <= i_point.point_word2;
                r_buf3 <= i_point.point_word3;
            end
            // drop a taken result
            if (r_out_valid && o_result.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (r_buf_valid) begin
                        r_buf_valid <= 1'b0;
                        r_pow       <= 1'b0;
                        r_op        <= OP_Y2;
                        if (w_oor) begin
                            r_res_on  <= 1'b0;
                            r_res_oor <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_MRD;
                        end
                    end
                end
                S_MRD: r_state <= S_MLD;
                S_MLD: begin
                    r_ma     <= (r_op == OP_DV) ? {1'b0, edpoc_pkg::CURVE_D} : {1'b0, r_rd_a};
                    r_mb     <= {1'b0, r_rd_b};
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_pvalid <= 1'b0;
                    r_state  <= S_MACC;
                end
                S_MACC: begin
                    // one partial product per cycle, accumulate the previous one
                    r_prod   <= 64'(r_ma[{r_cnt[5:3], 5'b0} +: 32])
                              * 64'(r_mb[{r_cnt[2:0], 5'b0} +: 32]);
                    r_pshift <= {1'b0, r_cnt[5:3]} + {1'b0, r_cnt[2:0]};
                    r_pvalid <= !r_cnt[6];
                    if (r_pvalid) begin
                        r_acc <= r_acc + w_pp;
                    end
                    if (r_cnt[6]) begin
                        r_state <= S_MRED;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_MRED: begin
                    if (w_hi != '0) begin
                        r_acc <= {249'b0, w_fold};
                    end else begin
                        r_state <= S_MWR;
                    end
                end
                S_MWR: begin
                    case (r_op)
                        OP_Y2: begin r_op <= OP_DV; r_state <= S_MRD; end
                        OP_DV: r_state <= S_ARD;
                        OP_XU: begin r_pow <= 1'b1; r_state <= S_INIT; end
                        default: begin
                            if ((r_op == OP_SQ) && w_exp_bit) begin
                                r_op    <= OP_MB;
                                r_state <= S_MRD;
                            end else if (r_bit != 8'd0) begin
                                r_bit   <= r_bit - 8'd1;
                                r_op    <= OP_SQ;
                                r_state <= S_MRD;
                            end else if (!r_pow) begin
                                r_op    <= OP_XU;
                                r_state <= S_MRD;
                            end else begin
                                r_state <= S_FRD;
                            end
                        end
                    endcase
                end
                S_ARD: r_state <= S_AU;
                S_AU:  r_state <= S_AV;
                S_AV:  r_state <= S_INIT;
                S_INIT: begin
                    r_bit   <= 8'd255;
                    r_op    <= OP_SQ;
                    r_state <= S_MRD;
                end
                S_FRD: r_state <= S_FCMP;
                S_FCMP: begin
                    r_res_on  <= (r_rd_a != edpoc_pkg::P_M1);
                    r_res_oor <= 1'b0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_on    <= r_res_on;
                        r_out_oor   <= r_res_oor;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "ed25519_point_on_curve_check_top_assert.svh"

    `EDPOC_ASSERT_NXT(a_macc_to_red, i_clk, i_rst_n, (r_state == S_MACC) && r_cnt[6], r_state == S_MRED)
    `EDPOC_ASSERT_IMP(a_mul_canon, i_clk, i_rst_n, r_state == S_MWR, w_canon < edpoc_pkg::P)
    `EDPOC_ASSERT_IMP(a_oor_not_on, i_clk, i_rst_n, r_out_valid && r_out_oor, !r_out_on)

endmodule

// File: tb/sv/edpoc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpoc_result_checker
// Watches the point and result channels of the Ed25519 point check, works out
// the expected verdict for every accepted request with its own mod-p
// arithmetic, and compares each accepted result with the oldest verdict.
// ----------------------------------------------------------------------------
module edpoc_result_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    edpoc_in_if   i_point,
    edpoc_out_if  i_result,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int              FE_W    = edpoc_pkg::FE_W;
    localparam logic [FE_W-1:0] P       = edpoc_pkg::P;
    localparam logic [FE_W-1:0] P_M1    = edpoc_pkg::P_M1;
    localparam logic [FE_W-1:0] CURVE_D = edpoc_pkg::CURVE_D;
    localparam logic [255:0]    EXP_INV = edpoc_pkg::EXP_INV;
    localparam logic [255:0]    EXP_LEG = edpoc_pkg::EXP_LEG;

    typedef struct packed {
        logic curve_ok;
        logic y_out_of_range;
    } t_verdict;

    t_verdict verdict_q[$];

    // a * b mod p on full-width products
    function automatic logic [FE_W-1:0] field_mul(logic [FE_W-1:0] a, logic [FE_W-1:0] b);
        logic [511:0] prod;
        prod = {257'b0, a} * {257'b0, b};
        return FE_W'(prod % {257'b0, P});
    endfunction

    // base ^ e mod p, square and multiply from the top bit down
    function automatic logic [FE_W-1:0] field_pow(logic [FE_W-1:0] base, logic [255:0] e);
        logic [FE_W-1:0] acc;
        acc = 255'd1;
        for (int k = 255; k >= 0; k--) begin
            acc = field_mul(acc, acc);
            if (e[k])
                acc = field_mul(acc, base);
        end
        return acc;
    endfunction

    function automatic t_verdict decompress_verdict(logic [63:0] w0, logic [63:0] w1,
                                                    logic [63:0] w2, logic [63:0] w3);
        t_verdict        vd;
        logic [FE_W-1:0] y, y2, u, v, x2, leg;
        y = {w3[62:0], w2, w1, w0};
        if (y >= P) begin
            vd.curve_ok       = 1'b0;
            vd.y_out_of_range = 1'b1;
            return vd;
        end
        y2  = field_mul(y, y);
        u   = FE_W'(({1'b0, y2} + {1'b0, P} - 256'd1) % {1'b0, P});
        v   = field_mul(CURVE_D, y2);
        v   = FE_W'(({1'b0, v} + 256'd1) % {1'b0, P});
        x2  = field_mul(field_pow(v, EXP_INV), u);
        leg = field_pow(x2, EXP_LEG);
        vd.curve_ok       = (leg != P_M1);
        vd.y_out_of_range = 1'b0;
        return vd;
    endfunction

    assign o_pending = verdict_q.size();

    // predict on each accepted point, compare on each accepted result
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_point.valid && i_point.ready)
                verdict_q.push_back(decompress_verdict(i_point.point_word0,
                    i_point.point_word1, i_point.point_word2, i_point.point_word3));
            if (i_result.valid && i_result.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with no request pending: curve_ok=%b oor=%b",
                             $time, i_result.curve_ok, i_result.y_out_of_range);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_result.curve_ok !== want.curve_ok ||
                        i_result.y_out_of_range !== want.y_out_of_range) begin
                        $display("%0t: mismatch expected curve_ok=%b oor=%b actual %b %b",
                                 $time, want.curve_ok, want.y_out_of_range,
                                 i_result.curve_ok, i_result.y_out_of_range);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_ed25519_point_on_curve_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ed25519_point_on_curve_check_top
// Drives compressed points into the Ed25519 point check in random bursts,
// stalls the result side on its own pattern, and reports the verdict of the
// result checker. Most random requests carry Y at or above p, which the block
// answers quickly; a share carry random in-range Y that take the long path.
// ----------------------------------------------------------------------------
module tb_ed25519_point_on_curve_check_top;

    localparam int IDLE_LIMIT  = 400000;
    localparam int RANDOM_REQS = 515;
    localparam int FAST_LEAD   = 40;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent_cnt;
    int   hold_at;
    int   burst_left;

    edpoc_in_if  point_if ();
    edpoc_out_if result_if ();

    ed25519_point_on_curve_check_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (point_if.sink),
        .o_result (result_if.source)
    );

    edpoc_result_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point      (point_if),
        .i_result     (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // offer one request and hold it until accepted; open a gap at burst end
    task automatic send_point(logic [63:0] w0, logic [63:0] w1,
                              logic [63:0] w2, logic [63:0] w3);
        int gap;
        point_if.valid       <= 1'b1;
        point_if.point_word0 <= w0;
        point_if.point_word1 <= w1;
        point_if.point_word2 <= w2;
        point_if.point_word3 <= w3;
        @(posedge i_clk iff (point_if.valid && point_if.ready));
        sent_cnt++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                point_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Y at or above p: upper words all ones, low word from p up to 2^64-1
    task automatic send_high_y();
        send_point(64'hFFFF_FFFF_FFFF_FFED + 64'($urandom_range(0, 18)),
                   {64{1'b1}}, {64{1'b1}}, {1'($urandom_range(0, 1)), {63{1'b1}}});
    endtask

    // result side: long hold-off once, otherwise stall in random stretches
    initial begin
        bit held;
        bit stall_mode;
        int stretch;
        held = 0;
        stall_mode = 0;
        stretch = 0;
        result_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && hold_at > 0 && sent_cnt >= hold_at) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1;
            end
            if (stretch == 0) begin
                stall_mode = $urandom_range(0, 1);
                stretch = $urandom_range(8, 80);
            end
            stretch--;
            result_if.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
            @(posedge i_clk);
        end
    end

    // end the run if nothing moves for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((point_if.valid && point_if.ready) || (result_if.valid && result_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [63:0] ones;
        ones = {64{1'b1}};
        sent_cnt = 0;
        hold_at = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        point_if.valid <= 1'b0;
        point_if.point_word0 <= '0;
        point_if.point_word1 <= '0;
        point_if.point_word2 <= '0;
        point_if.point_word3 <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, one, p-1 (x^2 zero), sign bit, boundary at p, all ones
        send_point(64'd0, 64'd0, 64'd0, 64'd0);
        send_point(64'd1, 64'd0, 64'd0, 64'd0);
        send_point(64'd1, 64'd0, 64'd0, 64'h8000_0000_0000_0000);
        send_point(64'hFFFF_FFFF_FFFF_FFEC, ones, ones, 64'h7FFF_FFFF_FFFF_FFFF);
        send_point(64'hFFFF_FFFF_FFFF_FFEC, ones, ones, ones);
        send_point(64'hFFFF_FFFF_FFFF_FFED, ones, ones, 64'h7FFF_FFFF_FFFF_FFFF);
        send_point(64'hFFFF_FFFF_FFFF_FFED, ones, ones, ones);
        send_point(64'hFFFF_FFFF_FFFF_FFF2, ones, ones, 64'h7FFF_FFFF_FFFF_FFFF);
        send_point(ones, ones, ones, ones);
        send_point(ones, ones, ones, 64'h7FFF_FFFF_FFFF_FFFF);
        send_point(64'd2, 64'd0, 64'd0, 64'd0);
        send_point(ones, ones, ones, 64'h7FFF_FFFF_FFFF_FFFE);
        send_point(64'd0, 64'd0, 64'd0, 64'h8000_0000_0000_0000);
        for (int k = 0; k < 4; k++)
            send_point(rand64(), rand64(), rand64(), rand64());

        // pause until every verdict is back
        point_if.valid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        @(posedge i_clk);

        // random: a fast lead-in fills the block during the long hold-off
        hold_at = sent_cnt + 3;
        for (int k = 0; k < RANDOM_REQS; k++) begin
            if (k >= FAST_LEAD && $urandom_range(0, 19) == 0)
                send_point(rand64(), rand64(), rand64(), rand64());
            else
                send_high_y();
        end
        point_if.valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/edpoc_pkg.sv
hdl/edpoc_if.sv
hdl/ed25519_point_on_curve_check_top.sv
tb/sv/edpoc_result_checker.sv
tb/sv/tb_ed25519_point_on_curve_check_top.sv
